// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for the clocked implication checks used in the framer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFDF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sfdf_pkg.sv =====
// ----------------------------------------------------------------------------
// Split-flap display framer package
// Item types, configuration, command codes and character mapping functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sfdf_pkg;

    localparam int MAX_LINES   = 4;
    localparam int MAX_COLUMNS = 12;
    localparam int CELL_COUNT  = MAX_LINES * MAX_COLUMNS;
    localparam int CELL_W      = $clog2(CELL_COUNT);

    // Command queue between the front and back parts (power of two).
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_IFACE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_ADDR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY      = 3'd4;

    localparam logic       IFACE_BUS  = 1'b0;
    localparam logic       IFACE_CTRL = 1'b1;
    localparam logic       MODE_SET   = 1'b0;
    localparam logic       MODE_TICK  = 1'b1;

    localparam logic [2:0] TYPE_ALNUM  = 3'd0;
    localparam logic [2:0] TYPE_HOUR   = 3'd1;
    localparam logic [2:0] TYPE_MINUTE = 3'd2;
    localparam logic [2:0] TYPE_FLAP40 = 3'd3;
    localparam logic [2:0] TYPE_FLAP62 = 3'd4;

    localparam logic [7:0] BYTE_BUS_SYNC = 8'hFF;
    localparam logic [7:0] BYTE_BUS_CMD  = 8'hC0;
    localparam logic [7:0] BYTE_SOH      = 8'h01;
    localparam logic [7:0] BYTE_CTRL_CMD = 8'h12;
    localparam logic [7:0] BYTE_STX      = 8'h02;
    localparam logic [7:0] BYTE_CTRL_SUB = 8'h08;
    localparam logic [7:0] BYTE_LF       = 8'h0A;
    localparam logic [7:0] BYTE_EOT      = 8'h04;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_EXCL  = 8'h21;
    localparam logic [7:0] CHAR_APOS  = 8'h27;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_Z     = 8'h5A;

    localparam logic [9:0] MAX_CTRL_ADDR = 10'd999;

    typedef struct packed {
        logic       mode;
        logic [9:0] module_address;
        logic [2:0] module_type;
        logic [7:0] value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_out_item;

    typedef struct packed {
        logic        interface_mode;
        logic [9:0]  controller_address;
        logic [2:0]  line_count;
        logic [3:0]  column_count;
        logic [23:0] update_delay_ticks;
    } t_cfg;

    typedef enum logic [1:0] {
        CMD_BUS,
        CMD_CELL,
        CMD_TICK
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [7:0]        addr_byte;
        logic [7:0]        data;
        logic [CELL_W-1:0] cell_idx;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic dirty;
        logic win_zero;
    } t_back_status;

    function automatic logic [2:0] f_eff_lines(input t_cfg cfg);
        return (cfg.line_count > 3'(MAX_LINES)) ? 3'(MAX_LINES) : cfg.line_count;
    endfunction

    function automatic logic [3:0] f_eff_cols(input t_cfg cfg);
        return (cfg.column_count > 4'(MAX_COLUMNS)) ? 4'(MAX_COLUMNS) : cfg.column_count;
    endfunction

    // Quotient by 100 through a row of independent threshold compares.
    function automatic logic [3:0] f_div100(input logic [9:0] a);
        logic [3:0] q;
        q = '0;
        for (int k = 1; k <= 10; k++) begin
            if (a >= 10'(k * 100)) begin
                q = q + 4'd1;
            end
        end
        return q;
    endfunction

    function automatic logic [3:0] f_div10(input logic [6:0] a);
        logic [3:0] q;
        q = '0;
        for (int k = 1; k <= 9; k++) begin
            if (a >= 7'(k * 10)) begin
                q = q + 4'd1;
            end
        end
        return q;
    endfunction

    function automatic logic [7:0] f_bus_position(input logic [2:0] t, input logic [7:0] v);
        logic [7:0] p;
        p = v;
        case (t)
            TYPE_ALNUM: begin
                if (v inside {[CHAR_A:CHAR_Z]}) p = v - CHAR_A;
                else if (v == CHAR_SLASH) p = 8'd26;
                else if (v == CHAR_DASH) p = 8'd27;
                else if (v inside {[CHAR_ONE:CHAR_NINE]}) p = v - CHAR_ONE + 8'd28;
                else if (v == CHAR_ZERO) p = 8'd37;
                else if (v == CHAR_DOT) p = 8'd38;
                else p = 8'd39;
            end
            TYPE_HOUR: begin
                p = (v > 8'd23) ? 8'd24 : v;
            end
            TYPE_MINUTE: begin
                if (v > 8'd59) p = 8'd29;
                else if (v < 8'd31) p = v + 8'd30;
                else p = v - 8'd31;
            end
            default: begin
                p = v;
            end
        endcase
        return p;
    endfunction

    function automatic logic [7:0] f_ctrl_char(input logic [2:0] t, input logic [7:0] v);
        logic [7:0] c;
        c = CHAR_SPACE;
        case (t)
            TYPE_ALNUM: begin
                c = (v < CHAR_SPACE) ? CHAR_SPACE : v;
            end
            TYPE_HOUR: begin
                c = (v > 8'd23) ? CHAR_SPACE : CHAR_A + v;
            end
            TYPE_MINUTE: begin
                if (v > 8'd59) c = CHAR_SPACE;
                else if (v < 8'd31) c = CHAR_A + v;
                else c = CHAR_EXCL + v - 8'd31;
            end
            TYPE_FLAP40: begin
                if (v == 8'd0) c = CHAR_SPACE;
                else if (v <= 8'd26) c = CHAR_A + v - 8'd1;
                else if (v == 8'd27) c = CHAR_APOS;
                else if (v == 8'd28) c = CHAR_DASH;
                else if (v <= 8'd37) c = CHAR_ONE + v - 8'd29;
                else if (v == 8'd38) c = CHAR_ZERO;
                else c = CHAR_SPACE;
            end
            TYPE_FLAP62: begin
                // Upper codes wrap around the 8-bit range.
                c = (v < 8'd31) ? CHAR_SPACE + v : CHAR_A + v - 8'd31;
            end
            default: begin
                c = CHAR_SPACE;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sfdf_queue.sv =====
// ----------------------------------------------------------------------------
// Framer command queue
// Short FIFO of classified commands between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module sfdf_queue
    import sfdf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_push_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output logic      o_empty
);

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sfdf_front.sv =====
// ----------------------------------------------------------------------------
// Framer front end
// Registers each input item, classifies it and queues a command for the back or drops it.
// ----------------------------------------------------------------------------
`default_nettype none

module sfdf_front
    import sfdf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    output logic          o_push,
    output t_cmd          o_push_cmd,
    input  wire logic     i_q_full
);

    t_in_item   r_item;
    logic       r_valid;
    logic [3:0] line;
    logic [6:0] col;
    logic [2:0] eff_lines;
    logic [3:0] eff_cols;
    logic       keep;
    t_cmd       cmd;

    assign o_in_stall = r_valid && i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_item <= i_in_item;
        end
    end

    always_comb begin
        line      = f_div100(r_item.module_address);
        col       = 7'(r_item.module_address - 10'(line) * 10'd100);
        eff_lines = f_eff_lines(i_cfg);
        eff_cols  = f_eff_cols(i_cfg);

        cmd.kind      = CMD_TICK;
        cmd.addr_byte = r_item.module_address[7:0];
        cmd.data      = f_ctrl_char(r_item.module_type, r_item.value);
        cmd.cell_idx  = CELL_W'(CELL_W'(line) * CELL_W'(MAX_COLUMNS) + CELL_W'(col));
        keep          = 1'b0;

        if (r_item.mode == MODE_TICK) begin
            // Ticks only matter to the controller window.
            cmd.kind = CMD_TICK;
            keep     = (i_cfg.interface_mode == IFACE_CTRL);
        end else if (r_item.module_type > TYPE_FLAP62) begin
            keep = 1'b0;
        end else if (i_cfg.interface_mode == IFACE_BUS) begin
            cmd.kind = CMD_BUS;
            cmd.data = f_bus_position(r_item.module_type, r_item.value);
            keep     = 1'b1;
        end else begin
            cmd.kind = CMD_CELL;
            keep     = (line < 4'(eff_lines)) && (col < 7'(eff_cols));
        end
    end

    assign o_push     = r_valid && !i_q_full && keep;
    assign o_push_cmd = cmd;

endmodule

`default_nettype wire

// ===== hw/rtl/sfdf_back.sv =====
// ----------------------------------------------------------------------------
// Framer back end
// Executes queued commands: bus frames, buffer updates and the tick window
// that sends the controller frame from the character buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module sfdf_back
    import sfdf_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_q_empty,
    input  wire t_cmd  i_head,
    output logic       o_pop,
    output logic       o_out_valid,
    input  wire logic  i_out_stall,
    output t_out_item  o_out_item,
    output t_back_status o_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_BUS,
        S_HDR,
        S_CELL,
        S_LOAD,
        S_END
    } t_state;

    t_state            r_state;
    logic [2:0]        r_step;
    t_cmd              r_cmd;
    logic [9:0]        r_rem;
    logic [2:0]        r_line;
    logic [3:0]        r_col;
    logic              r_dirty;
    logic [23:0]       r_window;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic [7:0]        r_mem [CELL_COUNT];
    logic              r_cell_ok [CELL_COUNT];
    logic [7:0]        r_rd_data;
    logic              r_rd_ok;

    logic              out_free;
    logic              out_load;
    logic [2:0]        eff_lines;
    logic [3:0]        eff_cols;
    logic [23:0]       delay;
    logic [23:0]       win_next;
    logic [9:0]        addr_clamped;
    logic [CELL_W-1:0] rd_addr;
    logic [7:0]        stored;
    logic              mem_we;
    logic [3:0]        hund;
    logic [3:0]        tens;
    logic [7:0]        hdr_byte;
    logic [7:0]        bus_byte;

    always_comb begin
        out_free     = !r_out_valid || !i_out_stall;
        eff_lines    = f_eff_lines(i_cfg);
        eff_cols     = f_eff_cols(i_cfg);
        // A new byte enters the output register in this cycle.
        out_load     = out_free && ((r_state inside {S_BUS, S_HDR, S_LOAD, S_END})
                     || ((r_state == S_CELL) && (r_col >= eff_cols)
                         && ((r_line + 3'd1) < eff_lines)));
        delay        = (i_cfg.update_delay_ticks == '0) ? 24'd1 : i_cfg.update_delay_ticks;
        win_next     = r_window + 24'd1;
        addr_clamped = (i_cfg.controller_address > MAX_CTRL_ADDR) ? MAX_CTRL_ADDR
                                                                  : i_cfg.controller_address;
        o_pop        = (r_state == S_IDLE) && !i_q_empty;
        rd_addr      = (r_state == S_IDLE) ? i_head.cell_idx
                     : CELL_W'(CELL_W'(r_line) * CELL_W'(MAX_COLUMNS) + CELL_W'(r_col));
        // A cell never written since reset reads as a space.
        stored       = r_rd_ok ? r_rd_data : CHAR_SPACE;
        mem_we       = (r_state == S_CMP) && (stored != r_cmd.data);
        hund         = f_div100(r_rem);
        tens         = f_div10(r_rem[6:0]);

        case (r_step)
            3'd0:    hdr_byte = BYTE_SOH;
            3'd1:    hdr_byte = BYTE_CTRL_CMD;
            3'd2:    hdr_byte = CHAR_ZERO + 8'(hund);
            3'd3:    hdr_byte = CHAR_ZERO + 8'(tens);
            3'd4:    hdr_byte = CHAR_ZERO + 8'(r_rem[3:0]);
            3'd5:    hdr_byte = BYTE_STX;
            default: hdr_byte = BYTE_CTRL_SUB;
        endcase

        case (r_step)
            3'd0:    bus_byte = BYTE_BUS_SYNC;
            3'd1:    bus_byte = BYTE_BUS_CMD;
            3'd2:    bus_byte = r_cmd.addr_byte;
            default: bus_byte = r_cmd.data;
        endcase
    end

    // Character buffer with a registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_cmd.cell_idx] <= r_cmd.data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CELL_COUNT; i++) begin
                r_cell_ok[i] <= 1'b0;
            end
            r_rd_ok <= 1'b0;
        end else begin
            if (mem_we) begin
                r_cell_ok[r_cmd.cell_idx] <= 1'b1;
            end
            r_rd_ok <= r_cell_ok[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_line      <= '0;
            r_col       <= '0;
            r_dirty     <= 1'b1;
            r_window    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_cmd <= i_head;
                        case (i_head.kind)
                            CMD_BUS: begin
                                r_step  <= '0;
                                r_state <= S_BUS;
                            end
                            CMD_CELL: begin
                                r_state <= S_CMP;
                            end
                            CMD_TICK: begin
                                if (r_dirty) begin
                                    if (win_next >= delay) begin
                                        r_dirty  <= 1'b0;
                                        r_window <= '0;
                                        r_rem    <= addr_clamped;
                                        r_step   <= '0;
                                        r_state  <= S_HDR;
                                    end else begin
                                        r_window <= win_next;
                                    end
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end

                S_CMP: begin
                    // A change opens a new window only if none is open yet.
                    if (mem_we && !r_dirty) begin
                        r_dirty  <= 1'b1;
                        r_window <= '0;
                    end
                    r_state <= S_IDLE;
                end

                S_BUS: begin
                    if (out_free) begin
                        r_out_valid          <= 1'b1;
                        r_out_item.out_byte  <= bus_byte;
                        r_out_item.last_byte <= (r_step == 3'd3);
                        r_step               <= r_step + 3'd1;
                        if (r_step == 3'd3) begin
                            r_state <= S_IDLE;
                        end
                    end
                end

                S_HDR: begin
                    if (out_free) begin
                        r_out_valid          <= 1'b1;
                        r_out_item.out_byte  <= hdr_byte;
                        r_out_item.last_byte <= 1'b0;
                        r_step               <= r_step + 3'd1;
                        // Peel one decimal digit of the address per byte.
                        if (r_step == 3'd2) begin
                            r_rem <= r_rem - 10'(hund) * 10'd100;
                        end
                        if (r_step == 3'd3) begin
                            r_rem <= r_rem - 10'(tens) * 10'd10;
                        end
                        if (r_step == 3'd6) begin
                            r_line  <= '0;
                            r_col   <= '0;
                            r_state <= (eff_lines == 3'd0) ? S_END : S_CELL;
                        end
                    end
                end

                S_CELL: begin
                    if (r_col < eff_cols) begin
                        // The read of this cell is issued in this cycle.
                        r_state <= S_LOAD;
                    end else if ((r_line + 3'd1) < eff_lines) begin
                        if (out_free) begin
                            r_out_valid          <= 1'b1;
                            r_out_item.out_byte  <= BYTE_LF;
                            r_out_item.last_byte <= 1'b0;
                            r_line               <= r_line + 3'd1;
                            r_col                <= '0;
                        end
                    end else begin
                        r_state <= S_END;
                    end
                end

                S_LOAD: begin
                    if (out_free) begin
                        r_out_valid          <= 1'b1;
                        r_out_item.out_byte  <= stored;
                        r_out_item.last_byte <= 1'b0;
                        r_col                <= r_col + 4'd1;
                        r_state              <= S_CELL;
                    end
                end

                S_END: begin
                    if (out_free) begin
                        r_out_valid          <= 1'b1;
                        r_out_item.out_byte  <= BYTE_EOT;
                        r_out_item.last_byte <= 1'b1;
                        r_state              <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out_item;
    assign o_status.busy     = (r_state != S_IDLE);
    assign o_status.dirty    = r_dirty;
    assign o_status.win_zero = (r_window == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/split_flap_display_framer_unit.sv =====
// Bus frame: 4 bytes, one per cycle unless the output stalls; sent from S_BUS after the queue pops.
// Buffer update: the back end pops the command and reads the cell, then compares and writes in S_CMP.
// Controller frame: header, each line's cells with a line feed between lines, then EOT, from S_HDR on.
// Items are taken at most one per cycle while the two-entry command queue has room.
// Reset: synchronous; all cells read as spaces at once, one frame pending, window at zero.
// ----------------------------------------------------------------------------
// Split-flap display framer
// Top level: configuration registers, front end, command queue and back end
// that turns module updates and ticks into bus or controller frames.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module split_flap_display_framer_unit
    import sfdf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,

    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_item,

    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_item
);

    t_cfg         r_cfg;
    logic         q_push;
    t_cmd         q_push_cmd;
    logic         q_full;
    logic         q_pop;
    t_cmd         q_head;
    logic         q_empty;
    t_back_status back_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interface_mode     <= IFACE_BUS;
            r_cfg.controller_address <= 10'd0;
            r_cfg.line_count         <= 3'd2;
            r_cfg.column_count       <= 4'd6;
            r_cfg.update_delay_ticks <= 24'd500;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IFACE_MODE: r_cfg.interface_mode     <= i_cfg_data[0];
                CFG_CTRL_ADDR:  r_cfg.controller_address <= i_cfg_data[9:0];
                CFG_LINE_COUNT: r_cfg.line_count         <= i_cfg_data[2:0];
                CFG_COL_COUNT:  r_cfg.column_count       <= i_cfg_data[3:0];
                CFG_DELAY:      r_cfg.update_delay_ticks <= i_cfg_data[23:0];
                default:        r_cfg <= r_cfg;
            endcase
        end
    end

    sfdf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_push     (q_push),
        .o_push_cmd (q_push_cmd),
        .i_q_full   (q_full)
    );

    sfdf_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (q_push_cmd),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_head     (q_head),
        .o_empty    (q_empty)
    );

    sfdf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (q_empty),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .o_status    (back_status)
    );

    `SFDF_ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, q_push, !q_full, "command pushed into a full queue")
    `SFDF_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, q_push, !q_empty, "pushed command not held in queue")
    `SFDF_ASSERT_IMPLY(a_frame_on_clean, i_clk, i_rst_n, $fell(back_status.dirty), back_status.busy, "buffer marked clean without a frame")
    `SFDF_ASSERT_IMPLY(a_clean_window, i_clk, i_rst_n, !back_status.dirty, back_status.win_zero, "window counting while buffer is clean")

endmodule

`default_nettype wire

// ===== tb/sv/split_flap_frame_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Split-flap framer frame checker
// Follows every register write and every accepted item, predicts the bytes
// of each bus or controller frame and compares them in order with the output.
// ----------------------------------------------------------------------------
`default_nettype none

module split_flap_frame_checker
    import sfdf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,

    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  wire t_in_item              i_in_item,

    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  wire t_out_item             i_out_item,

    output int                         o_mismatches,
    output int                         o_pending
);

    localparam int MAX_REPORTS = 10;

    t_cfg        settings;
    logic [7:0]  cells [CELL_COUNT];
    logic        dirty;
    logic [23:0] window;
    t_out_item   frame_bytes [$];
    int          mismatch_count;

    function automatic logic [7:0] flap_position(input logic [2:0] kind, input logic [7:0] v);
        logic [7:0] pos;
        pos = v;
        if (kind == TYPE_ALNUM) begin
            if (v >= CHAR_A && v <= CHAR_Z) pos = v - CHAR_A;
            else if (v == CHAR_SLASH) pos = 8'd26;
            else if (v == CHAR_DASH) pos = 8'd27;
            else if (v >= CHAR_ONE && v <= CHAR_NINE) pos = v - CHAR_ONE + 8'd28;
            else if (v == CHAR_ZERO) pos = 8'd37;
            else if (v == CHAR_DOT) pos = 8'd38;
            else pos = 8'd39;
        end else if (kind == TYPE_HOUR) begin
            pos = (v > 8'd23) ? 8'd24 : v;
        end else if (kind == TYPE_MINUTE) begin
            // Minute flaps start at minute 31, so minutes 0 to 30 sit at positions 30 to 60.
            if (v > 8'd59) pos = 8'd29;
            else if (v < 8'd31) pos = v + 8'd30;
            else pos = v - 8'd31;
        end
        return pos;
    endfunction

    function automatic logic [7:0] cell_char(input logic [2:0] kind, input logic [7:0] v);
        logic [7:0] ch;
        ch = CHAR_SPACE;
        case (kind)
            TYPE_ALNUM: begin
                if (v >= CHAR_SPACE) ch = v;
            end
            TYPE_HOUR: begin
                if (v <= 8'd23) ch = CHAR_A + v;
            end
            TYPE_MINUTE: begin
                if (v <= 8'd30) ch = CHAR_A + v;
                else if (v <= 8'd59) ch = CHAR_EXCL + (v - 8'd31);
            end
            TYPE_FLAP40: begin
                if (v >= 8'd1 && v <= 8'd26) ch = CHAR_A + (v - 8'd1);
                else if (v == 8'd27) ch = CHAR_APOS;
                else if (v == 8'd28) ch = CHAR_DASH;
                else if (v >= 8'd29 && v <= 8'd37) ch = CHAR_ONE + (v - 8'd29);
                else if (v == 8'd38) ch = CHAR_ZERO;
            end
            TYPE_FLAP62: begin
                // The upper range wraps around eight bits.
                ch = (v < 8'd31) ? CHAR_SPACE + v : CHAR_A + (v - 8'd31);
            end
            default: begin
            end
        endcase
        return ch;
    endfunction

    function automatic void queue_byte(input logic [7:0] b, input logic last);
        t_out_item entry;
        entry.out_byte  = b;
        entry.last_byte = last;
        frame_bytes = {frame_bytes, entry};
    endfunction

    function automatic void queue_controller_frame();
        int lines;
        int cols;
        int addr;
        lines = (settings.line_count > MAX_LINES) ? MAX_LINES : int'(settings.line_count);
        cols  = (settings.column_count > MAX_COLUMNS) ? MAX_COLUMNS : int'(settings.column_count);
        addr  = (settings.controller_address > MAX_CTRL_ADDR) ? int'(MAX_CTRL_ADDR)
                                                             : int'(settings.controller_address);
        queue_byte(BYTE_SOH, 1'b0);
        queue_byte(BYTE_CTRL_CMD, 1'b0);
        queue_byte(8'(CHAR_ZERO + addr / 100), 1'b0);
        queue_byte(8'(CHAR_ZERO + (addr / 10) % 10), 1'b0);
        queue_byte(8'(CHAR_ZERO + addr % 10), 1'b0);
        queue_byte(BYTE_STX, 1'b0);
        queue_byte(BYTE_CTRL_SUB, 1'b0);
        for (int l = 0; l < lines; l++) begin
            for (int c = 0; c < cols; c++) begin
                queue_byte(cells[l * MAX_COLUMNS + c], 1'b0);
            end
            if (l + 1 < lines) queue_byte(BYTE_LF, 1'b0);
        end
        queue_byte(BYTE_EOT, 1'b1);
    endfunction

    function automatic void reset_model();
        settings.interface_mode     = IFACE_BUS;
        settings.controller_address = 10'd0;
        settings.line_count         = 3'd2;
        settings.column_count       = 4'd6;
        settings.update_delay_ticks = 24'd500;
        for (int i = 0; i < CELL_COUNT; i++) cells[i] = CHAR_SPACE;
        dirty  = 1'b1;
        window = '0;
        frame_bytes.delete();
        mismatch_count = 0;
    endfunction

    function automatic void write_setting(input logic [CFG_IDX_W-1:0] index,
                                          input logic [CFG_DATA_W-1:0] data);
        case (index)
            CFG_IFACE_MODE: settings.interface_mode     = data[0];
            CFG_CTRL_ADDR:  settings.controller_address = data[9:0];
            CFG_LINE_COUNT: settings.line_count         = data[2:0];
            CFG_COL_COUNT:  settings.column_count       = data[3:0];
            CFG_DELAY:      settings.update_delay_ticks = data[23:0];
            default: begin
            end
        endcase
    endfunction

    function automatic void apply_item(input t_in_item it);
        logic [23:0] delay;
        int          lines;
        int          cols;
        int          line;
        int          col;
        int          idx;
        logic [7:0]  ch;
        if (it.mode == MODE_TICK) begin
            if (settings.interface_mode == IFACE_BUS || !dirty) return;
            delay  = (settings.update_delay_ticks == 0) ? 24'd1 : settings.update_delay_ticks;
            window = window + 24'd1;
            if (window < delay) return;
            dirty  = 1'b0;
            window = '0;
            queue_controller_frame();
            return;
        end
        if (it.module_type > TYPE_FLAP62) return;
        if (settings.interface_mode == IFACE_BUS) begin
            queue_byte(BYTE_BUS_SYNC, 1'b0);
            queue_byte(BYTE_BUS_CMD, 1'b0);
            queue_byte(it.module_address[7:0], 1'b0);
            queue_byte(flap_position(it.module_type, it.value), 1'b1);
            return;
        end
        lines = (settings.line_count > MAX_LINES) ? MAX_LINES : int'(settings.line_count);
        cols  = (settings.column_count > MAX_COLUMNS) ? MAX_COLUMNS : int'(settings.column_count);
        line  = it.module_address / 100;
        col   = it.module_address % 100;
        if (line >= lines || col >= cols) return;
        idx = line * MAX_COLUMNS + col;
        ch  = cell_char(it.module_type, it.value);
        if (cells[idx] != ch) begin
            cells[idx] = ch;
            // Only the first change opens a window; later ones ride along.
            if (!dirty) begin
                dirty  = 1'b1;
                window = '0;
            end
        end
    endfunction

    function automatic void check_byte(input t_out_item got);
        t_out_item want;
        if (frame_bytes.size() == 0) begin
            if (mismatch_count < MAX_REPORTS) begin
                $display("%0t: unexpected output byte %02h last %0b",
                         $time, got.out_byte, got.last_byte);
            end
            mismatch_count++;
            return;
        end
        want = frame_bytes.pop_front();
        if (want.out_byte != got.out_byte || want.last_byte != got.last_byte) begin
            if (mismatch_count < MAX_REPORTS) begin
                $display("%0t: frame byte mismatch: expected %02h last %0b, got %02h last %0b",
                         $time, want.out_byte, want.last_byte, got.out_byte, got.last_byte);
            end
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_cfg_valid && i_cfg_ready) write_setting(i_cfg_index, i_cfg_data);
            if (i_out_valid && !i_out_stall) check_byte(i_out_item);
            if (i_in_valid && !i_in_stall) apply_item(i_in_item);
        end
        o_mismatches <= mismatch_count;
        o_pending    <= frame_bytes.size();
    end

endmodule

`default_nettype wire

// ===== tb/sv/split_flap_display_framer_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Split-flap display framer testbench
// Drives bus and controller phases under several register settings with
// random idle gaps and output stalls; a checker beside the block compares
// every frame byte with its prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module split_flap_display_framer_unit_test;

    import sfdf_pkg::*;

    localparam int RESET_CYCLES   = 3;
    localparam int SETTLE_CYCLES  = 64;
    localparam int END_CYCLES     = 150;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 31;

    localparam logic [2:0]           TYPE_UNUSED = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 3'd5;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    t_in_item              in_item;
    logic                  out_valid;
    logic                  out_stall;
    t_out_item             out_item;
    int                    mismatches;
    int                    pending;
    int                    quiet_cycles;
    bit                    steady;
    bit                    long_hold_req;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    split_flap_display_framer_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    split_flap_frame_checker frame_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    function automatic t_in_item make_item(input logic mode, input logic [9:0] addr,
                                           input logic [2:0] kind, input logic [7:0] v);
        t_in_item it;
        it.mode           = mode;
        it.module_address = addr;
        it.module_type    = kind;
        it.value          = v;
        return it;
    endfunction

    // Half the values come from the edges of the mapping tables.
    function automatic logic [7:0] pick_value();
        if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 17))
            0:       return 8'd0;
            1:       return 8'd23;
            2:       return 8'd24;
            3:       return 8'd30;
            4:       return 8'd31;
            5:       return 8'd38;
            6:       return 8'd39;
            7:       return 8'd59;
            8:       return 8'd60;
            9:       return 8'd255;
            10:      return CHAR_SPACE - 8'd1;
            11:      return CHAR_A;
            12:      return CHAR_Z;
            13:      return CHAR_ZERO;
            14:      return CHAR_NINE;
            15:      return CHAR_DOT;
            16:      return CHAR_SLASH;
            default: return CHAR_DASH;
        endcase
    endfunction

    function automatic t_in_item random_bus_item();
        t_in_item it;
        it.mode           = ($urandom_range(0, 9) == 0) ? MODE_TICK : MODE_SET;
        it.module_address = 10'($urandom_range(0, 1023));
        if ($urandom_range(0, 9) == 0) begin
            it.module_type = 3'($urandom_range(TYPE_FLAP62 + 1, TYPE_UNUSED));
        end else begin
            it.module_type = 3'($urandom_range(TYPE_ALNUM, TYPE_FLAP62));
        end
        it.value = pick_value();
        return it;
    endfunction

    // Mostly ticks and writes to cells in use; the rest hit random addresses.
    function automatic t_in_item random_ctrl_item(input int lines, input int cols);
        t_in_item it;
        int       roll;
        it   = random_bus_item();
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            it.mode = MODE_TICK;
        end else begin
            it.mode = MODE_SET;
            if (roll < 85 && lines > 0 && cols > 0) begin
                it.module_address = 10'($urandom_range(0, lines - 1) * 100
                                        + $urandom_range(0, cols - 1));
                it.module_type    = 3'($urandom_range(TYPE_ALNUM, TYPE_FLAP62));
            end
        end
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Unused upper data bits carry noise; the block must ignore them.
    task automatic configure(input logic iface, input logic [9:0] addr, input logic [2:0] lines,
                             input logic [3:0] cols, input logic [23:0] delay);
        logic [23:0] junk;
        junk = 24'($urandom);
        write_register(CFG_IFACE_MODE, {junk[23:1], iface});
        write_register(CFG_CTRL_ADDR, {junk[23:10], addr});
        write_register(CFG_LINE_COUNT, {junk[23:3], lines});
        write_register(CFG_COL_COUNT, {junk[23:4], cols});
        write_register(CFG_DELAY, delay);
    endtask

    // Wait for every predicted byte, then give items without output time to finish.
    task automatic settle(input int cycles);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (cycles) @(posedge clk);
    endtask

    task automatic run_phase(input logic iface, input logic [9:0] addr, input logic [2:0] lines,
                             input logic [3:0] cols, input logic [23:0] delay, input int count);
        int eff_lines;
        int eff_cols;
        settle(SETTLE_CYCLES);
        configure(iface, addr, lines, cols, delay);
        eff_lines = (lines > MAX_LINES) ? MAX_LINES : int'(lines);
        eff_cols  = (cols > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols);
        steady    = ($urandom_range(0, 3) == 0);
        repeat (count) begin
            if (iface == IFACE_BUS) send_item(random_bus_item());
            else send_item(random_ctrl_item(eff_lines, eff_cols));
        end
    endtask

    initial begin : out_stall_driver
        int hold;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            hold = steady ? 0 : $urandom_range(0, 5);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        in_item       = '0;
        quiet_cycles  = 0;
        steady        = 1'b0;
        long_hold_req = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Bus mode after reset: alphanumeric letters, slash, zero, dot and others, hour and minute limits.
        send_item(make_item(MODE_SET, 10'd0, TYPE_ALNUM, CHAR_A));
        send_item(make_item(MODE_SET, 10'd1023, TYPE_ALNUM, CHAR_Z));
        send_item(make_item(MODE_SET, 10'd17, TYPE_ALNUM, CHAR_SLASH));
        send_item(make_item(MODE_SET, 10'd300, TYPE_ALNUM, CHAR_ZERO));
        send_item(make_item(MODE_SET, 10'd511, TYPE_ALNUM, CHAR_DOT));
        send_item(make_item(MODE_SET, 10'd999, TYPE_ALNUM, 8'hFF));
        send_item(make_item(MODE_SET, 10'd42, TYPE_HOUR, 8'd24));
        send_item(make_item(MODE_SET, 10'd43, TYPE_MINUTE, 8'd31));
        send_item(make_item(MODE_SET, 10'd44, TYPE_MINUTE, 8'd60));
        send_item(make_item(MODE_SET, 10'd255, TYPE_FLAP40, 8'hAA));
        send_item(make_item(MODE_SET, 10'd5, TYPE_UNUSED, CHAR_A));
        send_item(make_item(MODE_TICK, 10'd0, TYPE_ALNUM, 8'd0));

        // Bus items keep coming while the output is held off for a long time.
        steady        = 1'b1;
        long_hold_req = 1'b1;
        repeat (40) send_item(random_bus_item());
        steady = 1'b0;

        settle(SETTLE_CYCLES);
        configure(IFACE_CTRL, 10'd123, 3'd4, 4'd12, 24'd1);
        write_register(CFG_UNUSED, 24'($urandom));
        // The frame pending since reset goes out on the first tick.
        send_item(make_item(MODE_TICK, 10'd0, TYPE_ALNUM, 8'd0));
        send_item(make_item(MODE_SET, 10'd0, TYPE_FLAP40, 8'd1));
        send_item(make_item(MODE_SET, 10'd311, TYPE_FLAP62, 8'd255));
        send_item(make_item(MODE_SET, 10'd400, TYPE_ALNUM, CHAR_A));
        send_item(make_item(MODE_SET, 10'd12, TYPE_ALNUM, CHAR_A));
        send_item(make_item(MODE_SET, 10'd1023, TYPE_ALNUM, CHAR_A));
        send_item(make_item(MODE_SET, 10'd0, TYPE_FLAP40, 8'd1));
        send_item(make_item(MODE_SET, 10'd105, TYPE_UNUSED, CHAR_A));
        send_item(make_item(MODE_TICK, 10'd0, TYPE_ALNUM, 8'd0));
        send_item(make_item(MODE_TICK, 10'd0, TYPE_ALNUM, 8'd0));
        send_item(make_item(MODE_SET, 10'd211, TYPE_HOUR, 8'd24));
        send_item(make_item(MODE_TICK, 10'd0, TYPE_ALNUM, 8'd0));
        send_item(make_item(MODE_SET, 10'd211, TYPE_MINUTE, 8'd31));
        send_item(make_item(MODE_TICK, 10'd0, TYPE_ALNUM, 8'd0));

        // The long windows leave the buffer dirty so that the frames with no
        // rows and with empty rows that follow them really go out.
        run_phase(IFACE_CTRL, 10'd999, 3'd4, 4'd12, 24'd2, PHASE_ITEMS);
        run_phase(IFACE_CTRL, 10'd0, 3'd1, 4'd1, 24'd1, PHASE_ITEMS);
        run_phase(IFACE_CTRL, 10'd7, 3'd2, 4'd6, 24'hFFFFFF, PHASE_ITEMS);
        run_phase(IFACE_CTRL, 10'd1023, 3'd0, 4'd5, 24'd3, PHASE_ITEMS);
        run_phase(IFACE_CTRL, 10'd42, 3'd3, 4'd15, 24'd1000, PHASE_ITEMS);
        run_phase(IFACE_CTRL, 10'd500, 3'd7, 4'd0, 24'd0, PHASE_ITEMS);
        run_phase(IFACE_BUS, 10'd999, 3'd1, 4'd12, 24'd500, 20);

        settle(END_CYCLES);
        if (mismatches == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
